FILE: hdl/irds_pkg.sv
// Shared types, constants and helpers for the region difference statistics block.
package irds_pkg;

	localparam int unsigned MAX_REF_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_REF_HEIGHT_DEF = 1024;
	localparam int unsigned MAX_SCREEN_DIM_DEF = 4096;

	localparam int unsigned DIM_W   = 13;
	localparam int unsigned REF_W   = 11;
	localparam int unsigned SCR_W   = 15;
	localparam int unsigned POS_W   = 13;
	localparam int unsigned AX_W    = 16;
	localparam int unsigned N_W     = 22;
	localparam int unsigned NUM_W   = 42;
	localparam int unsigned DEN_W   = 25;
	localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);
	localparam int unsigned CIDX_W  = 3;

	localparam logic [7:0]  THRESHOLD  = 8'd16;
	localparam logic [7:0]  FULL_DIFF  = 8'd255;
	localparam logic [9:0]  FULL_SUM   = 10'd765;
	localparam logic [10:0] MEAN_SCALE = 11'd2000;
	localparam logic [17:0] PCT_SCALE  = 18'd200000;
	localparam logic [17:0] MEAN_MAX   = 18'd255000;
	localparam logic [16:0] PCT_MAX    = 17'd100000;

	localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [REF_W-1:0] RST_REF_WIDTH     = 11'd64;
	localparam logic [REF_W-1:0] RST_REF_HEIGHT    = 11'd64;

	typedef enum logic [CIDX_W-1:0] {
		CFG_SCREEN_WIDTH  = 3'd0,
		CFG_SCREEN_HEIGHT = 3'd1,
		CFG_OFFSET_X      = 3'd2,
		CFG_OFFSET_Y      = 3'd3,
		CFG_REF_WIDTH     = 3'd4,
		CFG_REF_HEIGHT    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] ref_red;
		logic [7:0] ref_green;
		logic [7:0] ref_blue;
		logic [7:0] scr_red;
		logic [7:0] scr_green;
		logic [7:0] scr_blue;
	} pixel_t;

	typedef struct packed {
		logic [17:0] mean_milli;
		logic [7:0]  max_diff;
		logic [16:0] pct_milli;
		logic [29:0] diff_sum;
		logic [20:0] over_count;
	} result_t;

	typedef struct packed {
		logic [REF_W-1:0] rw;
		logic [REF_W-1:0] rh;
		logic [SCR_W-1:0] sw;
		logic [SCR_W-1:0] sh;
		logic [DIM_W-1:0] ox;
		logic [DIM_W-1:0] oy;
	} geom_t;

	typedef struct packed {
		logic [9:0] sum_add;
		logic [7:0] max_val;
		logic       over;
		logic       last;
	} px_rec_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_MUL,
		BK_MEAN_GO,
		BK_MEAN_WAIT,
		BK_PCT_GO,
		BK_PCT_WAIT,
		BK_PUT
	} back_state_t;

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: hdl/irds_queue.sv
// Short queue of classified pixel records between the front and back parts.
module irds_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  irds_pkg::px_rec_t wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output irds_pkg::px_rec_t rd_data,
	output logic             q_empty
);

	irds_pkg::px_rec_t mem_q [irds_pkg::QDEPTH];
	logic [irds_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [irds_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [irds_pkg::QPTR_W:0]   count_q;

	assign q_full  = (count_q == (irds_pkg::QPTR_W + 1)'(irds_pkg::QDEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/irds_front.sv
// Front part: tracks position, checks screen bounds and classifies each pixel.
module irds_front #(
	parameter int unsigned MAX_REF_WIDTH  = irds_pkg::MAX_REF_WIDTH_DEF,
	parameter int unsigned MAX_REF_HEIGHT = irds_pkg::MAX_REF_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  irds_pkg::geom_t   geom,
	input  logic              push,
	output logic              full,
	input  irds_pkg::pixel_t  pixel,
	output logic              q_push,
	input  logic              q_full,
	output irds_pkg::px_rec_t q_data
);

	localparam int unsigned COL_W = (MAX_REF_WIDTH > 1) ? $clog2(MAX_REF_WIDTH) : 1;
	localparam int unsigned ROW_W = (MAX_REF_HEIGHT > 1) ? $clog2(MAX_REF_HEIGHT) : 1;

	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;

	logic [irds_pkg::AX_W-1:0] ax;
	logic [irds_pkg::AX_W-1:0] ay;
	logic                      outside;
	logic                      col_end;
	logic                      row_end;
	logic [7:0]                d_r;
	logic [7:0]                d_g;
	logic [7:0]                d_b;
	logic [7:0]                d_max;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		ax = {{(irds_pkg::AX_W - irds_pkg::DIM_W){geom.ox[irds_pkg::DIM_W-1]}}, geom.ox}
			+ irds_pkg::AX_W'(column_q);
		ay = {{(irds_pkg::AX_W - irds_pkg::DIM_W){geom.oy[irds_pkg::DIM_W-1]}}, geom.oy}
			+ irds_pkg::AX_W'(row_q);
		outside = ax[irds_pkg::AX_W-1] || ay[irds_pkg::AX_W-1]
			|| (ax >= irds_pkg::AX_W'(geom.sw)) || (ay >= irds_pkg::AX_W'(geom.sh));

		col_end = (irds_pkg::POS_W'(column_q)
			>= (irds_pkg::POS_W'(geom.rw) - irds_pkg::POS_W'(1)));
		row_end = (irds_pkg::POS_W'(row_q)
			>= (irds_pkg::POS_W'(geom.rh) - irds_pkg::POS_W'(1)));

		d_r   = irds_pkg::absdiff(pixel.scr_red, pixel.ref_red);
		d_g   = irds_pkg::absdiff(pixel.scr_green, pixel.ref_green);
		d_b   = irds_pkg::absdiff(pixel.scr_blue, pixel.ref_blue);
		d_max = (d_r > d_g) ? d_r : d_g;
		d_max = (d_b > d_max) ? d_b : d_max;

		if (outside) begin
			q_data.sum_add = irds_pkg::FULL_SUM;
			q_data.max_val = irds_pkg::FULL_DIFF;
			q_data.over    = 1'b1;
		end else begin
			q_data.sum_add = 10'(d_r) + 10'(d_g) + 10'(d_b);
			q_data.max_val = d_max;
			q_data.over    = (d_max > irds_pkg::THRESHOLD);
		end
		q_data.last = col_end && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (q_push) begin
			if (col_end) begin
				column_q <= '0;
				row_q    <= row_end ? '0 : row_q + 1'b1;
			end else begin
				column_q <= column_q + 1'b1;
			end
		end
	end

endmodule

FILE: hdl/irds_div.sv
// Bit-serial restoring divider shared by the mean and percentage results.
module irds_div (
	input  logic               clk,
	input  logic               arst_n,
	input  irds_pkg::div_req_t req,
	output irds_pkg::div_rsp_t rsp
);

	logic [irds_pkg::NUM_W-1:0] num_q;
	logic [irds_pkg::DEN_W-1:0] den_q;
	logic [irds_pkg::DEN_W-1:0] rem_q;
	logic [irds_pkg::CNT_W-1:0] cnt_q;
	logic                       done_q;

	logic [irds_pkg::DEN_W:0] rem_sh;
	logic                     ge;

	assign rem_sh   = {rem_q, num_q[irds_pkg::NUM_W-1]};
	assign ge       = (rem_sh >= {1'b0, den_q});
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

	always_ff @(posedge clk) begin
		if (req.start && cnt_q == '0) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? irds_pkg::DEN_W'(rem_sh - {1'b0, den_q})
				: irds_pkg::DEN_W'(rem_sh);
			num_q <= {num_q[irds_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == irds_pkg::CNT_W'(1));
			if (req.start && cnt_q == '0) begin
				cnt_q <= irds_pkg::CNT_W'(irds_pkg::NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/irds_back.sv
// Back part: accumulates records, scales and divides at image end, holds the result.
module irds_back (
	input  logic               clk,
	input  logic               arst_n,
	input  irds_pkg::geom_t    geom,
	output logic               q_pop,
	input  logic               q_empty,
	input  irds_pkg::px_rec_t  q_data,
	output irds_pkg::div_req_t div_req,
	input  irds_pkg::div_rsp_t div_rsp,
	output logic               empty,
	input  logic               pop,
	output irds_pkg::result_t  result
);

	irds_pkg::back_state_t state_q;
	irds_pkg::back_state_t state_d;

	logic [29:0] sum_acc_q;
	logic [7:0]  max_acc_q;
	logic [20:0] over_acc_q;
	logic [29:0] sum_fin_q;
	logic [7:0]  max_fin_q;
	logic [20:0] over_fin_q;
	logic [irds_pkg::N_W-1:0]   n_q;
	logic [irds_pkg::NUM_W-1:0] mean_num_q;
	logic [irds_pkg::NUM_W-1:0] pct_num_q;
	logic [irds_pkg::DEN_W-1:0] mean_den_q;
	logic [irds_pkg::DEN_W-1:0] pct_den_q;
	logic [17:0] mean_q;
	logic [16:0] pct_q;
	irds_pkg::result_t result_q;
	logic        out_valid_q;

	logic [29:0] sum_new;
	logic [7:0]  max_new;
	logic [20:0] over_new;

	assign sum_new  = sum_acc_q + 30'(q_data.sum_add);
	assign max_new  = (q_data.max_val > max_acc_q) ? q_data.max_val : max_acc_q;
	assign over_new = over_acc_q + 21'(q_data.over);
	assign empty    = !out_valid_q;
	assign result   = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irds_pkg::BK_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		q_pop         = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = mean_num_q;
		div_req.den   = mean_den_q;
		unique case (state_q)
			irds_pkg::BK_RUN: begin
				q_pop = !q_empty;
				if (!q_empty && q_data.last) begin
					state_d = irds_pkg::BK_MUL;
				end
			end
			irds_pkg::BK_MUL: begin
				state_d = irds_pkg::BK_MEAN_GO;
			end
			irds_pkg::BK_MEAN_GO: begin
				div_req.start = 1'b1;
				state_d       = irds_pkg::BK_MEAN_WAIT;
			end
			irds_pkg::BK_MEAN_WAIT: begin
				if (div_rsp.done) begin
					state_d = irds_pkg::BK_PCT_GO;
				end
			end
			irds_pkg::BK_PCT_GO: begin
				div_req.start = 1'b1;
				div_req.num   = pct_num_q;
				div_req.den   = pct_den_q;
				state_d       = irds_pkg::BK_PCT_WAIT;
			end
			irds_pkg::BK_PCT_WAIT: begin
				if (div_rsp.done) begin
					state_d = irds_pkg::BK_PUT;
				end
			end
			irds_pkg::BK_PUT: begin
				if (!out_valid_q) begin
					state_d = irds_pkg::BK_RUN;
				end
			end
			default: begin
				state_d = irds_pkg::BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_acc_q  <= '0;
			max_acc_q  <= '0;
			over_acc_q <= '0;
		end else if (q_pop) begin
			if (q_data.last) begin
				sum_acc_q  <= '0;
				max_acc_q  <= '0;
				over_acc_q <= '0;
			end else begin
				sum_acc_q  <= sum_new;
				max_acc_q  <= max_new;
				over_acc_q <= over_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			sum_fin_q  <= sum_new;
			max_fin_q  <= max_new;
			over_fin_q <= over_new;
			n_q        <= irds_pkg::N_W'(geom.rw) * irds_pkg::N_W'(geom.rh);
		end
		if (state_q == irds_pkg::BK_MUL) begin
			mean_num_q <= irds_pkg::NUM_W'(sum_fin_q) * irds_pkg::NUM_W'(irds_pkg::MEAN_SCALE)
				+ irds_pkg::NUM_W'({n_q, 1'b0}) + irds_pkg::NUM_W'(n_q);
			pct_num_q  <= irds_pkg::NUM_W'(over_fin_q) * irds_pkg::NUM_W'(irds_pkg::PCT_SCALE)
				+ irds_pkg::NUM_W'(n_q);
			mean_den_q <= irds_pkg::DEN_W'({n_q, 2'b00}) + irds_pkg::DEN_W'({n_q, 1'b0});
			pct_den_q  <= irds_pkg::DEN_W'({n_q, 1'b0});
		end
		if (state_q == irds_pkg::BK_MEAN_WAIT && div_rsp.done) begin
			mean_q <= (div_rsp.quo > irds_pkg::NUM_W'(irds_pkg::MEAN_MAX))
				? irds_pkg::MEAN_MAX : div_rsp.quo[17:0];
		end
		if (state_q == irds_pkg::BK_PCT_WAIT && div_rsp.done) begin
			pct_q <= (div_rsp.quo > irds_pkg::NUM_W'(irds_pkg::PCT_MAX))
				? irds_pkg::PCT_MAX : div_rsp.quo[16:0];
		end
		if (state_q == irds_pkg::BK_PUT && !out_valid_q) begin
			result_q.mean_milli <= mean_q;
			result_q.max_diff   <= max_fin_q;
			result_q.pct_milli  <= pct_q;
			result_q.diff_sum   <= sum_fin_q;
			result_q.over_count <= over_fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end else if (state_q == irds_pkg::BK_PUT) begin
			out_valid_q <= 1'b1;
		end
	end

endmodule

FILE: hdl/image_region_difference_stats.sv
// Top level of the region difference statistics block: configuration and part wiring.
//
//   port group       direction  handshake             request moved
//   push/full/pixel  in         push & !full          one reference/screen pixel pair
//   empty/pop/result out        pop & !empty          statistics of one finished image
//   cfg_*            in         cfg_valid & cfg_ready one register write (ready always high)
//
// One pixel a cycle enters while the four-entry queue has room.
// The last pixel of an image holds the back part while the shared bit-serial divider
// runs, 42 steps for the mean and then the same for the percentage; its result reaches
// the ports after the multiply, mean-divide, percentage-divide and put states.
// Meanwhile pixels enter only until the queue holds four, then full stays high;
// a result still waiting to be popped holds the back part, and so the input, likewise once the next result is ready.
// Reset is asynchronous and immediate; no clearing pass.
module image_region_difference_stats #(
	parameter int unsigned MAX_REF_WIDTH  = irds_pkg::MAX_REF_WIDTH_DEF,
	parameter int unsigned MAX_REF_HEIGHT = irds_pkg::MAX_REF_HEIGHT_DEF,
	parameter int unsigned MAX_SCREEN_DIM = irds_pkg::MAX_SCREEN_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  irds_pkg::pixel_t             pixel,
	output logic                         empty,
	input  logic                         pop,
	output irds_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [irds_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [irds_pkg::DIM_W-1:0]   cfg_data
);

	logic [irds_pkg::DIM_W-1:0] screen_width_q;
	logic [irds_pkg::DIM_W-1:0] screen_height_q;
	logic [irds_pkg::DIM_W-1:0] offset_x_q;
	logic [irds_pkg::DIM_W-1:0] offset_y_q;
	logic [irds_pkg::REF_W-1:0] ref_width_q;
	logic [irds_pkg::REF_W-1:0] ref_height_q;

	irds_pkg::geom_t    geom;
	irds_pkg::px_rec_t  wr_rec;
	irds_pkg::px_rec_t  rd_rec;
	irds_pkg::div_req_t div_req;
	irds_pkg::div_rsp_t div_rsp;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= irds_pkg::RST_SCREEN_WIDTH;
			screen_height_q <= irds_pkg::RST_SCREEN_HEIGHT;
			offset_x_q      <= '0;
			offset_y_q      <= '0;
			ref_width_q     <= irds_pkg::RST_REF_WIDTH;
			ref_height_q    <= irds_pkg::RST_REF_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				irds_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				irds_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				irds_pkg::CFG_OFFSET_X:      offset_x_q      <= cfg_data;
				irds_pkg::CFG_OFFSET_Y:      offset_y_q      <= cfg_data;
				irds_pkg::CFG_REF_WIDTH:     ref_width_q     <= cfg_data[irds_pkg::REF_W-1:0];
				irds_pkg::CFG_REF_HEIGHT:    ref_height_q    <= cfg_data[irds_pkg::REF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ref_width_q == '0) begin
			geom.rw = irds_pkg::REF_W'(1);
		end else if (32'(ref_width_q) > MAX_REF_WIDTH) begin
			geom.rw = irds_pkg::REF_W'(MAX_REF_WIDTH);
		end else begin
			geom.rw = ref_width_q;
		end
		if (ref_height_q == '0) begin
			geom.rh = irds_pkg::REF_W'(1);
		end else if (32'(ref_height_q) > MAX_REF_HEIGHT) begin
			geom.rh = irds_pkg::REF_W'(MAX_REF_HEIGHT);
		end else begin
			geom.rh = ref_height_q;
		end
		geom.sw = (32'(screen_width_q) > MAX_SCREEN_DIM)
			? irds_pkg::SCR_W'(MAX_SCREEN_DIM) : irds_pkg::SCR_W'(screen_width_q);
		geom.sh = (32'(screen_height_q) > MAX_SCREEN_DIM)
			? irds_pkg::SCR_W'(MAX_SCREEN_DIM) : irds_pkg::SCR_W'(screen_height_q);
		geom.ox = offset_x_q;
		geom.oy = offset_y_q;
	end

	irds_front #(
		.MAX_REF_WIDTH  (MAX_REF_WIDTH),
		.MAX_REF_HEIGHT (MAX_REF_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.push   (push),
		.full   (full),
		.pixel  (pixel),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (wr_rec)
	);

	irds_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (wr_rec),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (rd_rec),
		.q_empty (q_empty)
	);

	irds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	irds_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.q_pop   (q_pop),
		.q_empty (q_empty),
		.q_data  (rd_rec),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

FILE: hdl/irds_chk.sv
// Port-level checks on results of the region difference statistics block, with bind.
module irds_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input irds_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.mean_milli <= irds_pkg::MEAN_MAX
			&& result.pct_milli <= irds_pkg::PCT_MAX))
		else $error("scaled result beyond saturation limit");

	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.diff_sum == '0) |-> (result.mean_milli == '0))
		else $error("non-zero mean from zero difference sum");

	a_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.max_diff == '0) |-> (result.diff_sum == '0))
		else $error("difference sum without any difference");

	a_low_max: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.max_diff <= irds_pkg::THRESHOLD)
			|-> (result.over_count == '0 && result.pct_milli == '0))
		else $error("pixels counted although no difference exceeds threshold");

endmodule

bind image_region_difference_stats irds_chk u_chk (.*);

FILE: sim/tb_image_region_difference_stats.sv
// Self-checking testbench for the region difference statistics block.
`timescale 1ns / 100ps

module tb_image_region_difference_stats;
	import irds_pkg::*;

	localparam int DRAIN_CYCLES = 160;
	localparam int RANDOM_ITEMS = 1900;

	typedef enum logic [1:0] {
		STEP_REG,
		STEP_PIXEL,
		STEP_PIXEL_KNOWN
	} step_kind_t;

	typedef struct {
		step_kind_t  kind;
		cfg_idx_t    idx;
		logic [12:0] value;
		pixel_t      px;
		result_t     known;
	} step_t;

	typedef struct packed {
		logic [12:0] sw;
		logic [12:0] sh;
		logic [12:0] ox;
		logic [12:0] oy;
		logic [12:0] rw;
		logic [12:0] rh;
	} geometry_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic                full;
	pixel_t              pixel     = '0;
	logic                empty;
	logic                pop       = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [DIM_W-1:0]    cfg_data  = '0;

	logic [12:0] scr_w_reg = RST_SCREEN_WIDTH;
	logic [12:0] scr_h_reg = RST_SCREEN_HEIGHT;
	logic [12:0] off_x_reg = '0;
	logic [12:0] off_y_reg = '0;
	logic [10:0] ref_w_reg = RST_REF_WIDTH;
	logic [10:0] ref_h_reg = RST_REF_HEIGHT;

	logic [9:0]  col_pos  = '0;
	logic [9:0]  row_pos  = '0;
	logic [29:0] sum_acc  = '0;
	logic [7:0]  max_acc  = '0;
	logic [20:0] over_acc = '0;

	result_t stats_due [$];
	step_t   opening [$];
	int      gap_pct  = 0;
	int      hold_pct = 0;
	int      sent     = 0;
	int      faults   = 0;

	image_region_difference_stats u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void tally_pixel(input pixel_t px, output bit done,
			output result_t stats);
		int rw, rh, sw, sh, ox, oy, ax, ay, k;
		longint unsigned n, mean, pct;
		logic [7:0] rv [3];
		logic [7:0] sv [3];
		logic [7:0] d;
		bit over;
		rw = int'(ref_w_reg);
		rh = int'(ref_h_reg);
		if (rw < 1) rw = 1;
		if (rw > 1024) rw = 1024;
		if (rh < 1) rh = 1;
		if (rh > 1024) rh = 1024;
		sw = int'(scr_w_reg);
		sh = int'(scr_h_reg);
		if (sw > 4096) sw = 4096;
		if (sh > 4096) sh = 4096;
		ox = $signed(off_x_reg);
		oy = $signed(off_y_reg);
		ax = ox + int'(col_pos);
		ay = oy + int'(row_pos);
		done = 1'b0;
		stats = '0;
		if (ax < 0 || ay < 0 || ax >= sw || ay >= sh) begin
			sum_acc = sum_acc + 30'd765;
			max_acc = 8'd255;
			over_acc = over_acc + 21'd1;
		end else begin
			rv[0] = px.ref_red;
			rv[1] = px.ref_green;
			rv[2] = px.ref_blue;
			sv[0] = px.scr_red;
			sv[1] = px.scr_green;
			sv[2] = px.scr_blue;
			over = 1'b0;
			for (k = 0; k < 3; k++) begin
				d = (rv[k] > sv[k]) ? rv[k] - sv[k] : sv[k] - rv[k];
				sum_acc = sum_acc + 30'(d);
				if (d > max_acc) max_acc = d;
				if (d > 8'd16) over = 1'b1;
			end
			if (over) over_acc = over_acc + 21'd1;
		end
		if (int'(col_pos) >= rw - 1) begin
			col_pos = '0;
			if (int'(row_pos) >= rh - 1) begin
				row_pos = '0;
				done = 1'b1;
			end else begin
				row_pos = row_pos + 10'd1;
			end
		end else begin
			col_pos = col_pos + 10'd1;
		end
		if (done) begin
			n = longint'(rw) * longint'(rh);
			mean = (64'(sum_acc) * 2000 + 3 * n) / (6 * n);
			pct = (64'(over_acc) * 200000 + n) / (2 * n);
			if (mean > 255000) mean = 255000;
			if (pct > 100000) pct = 100000;
			stats.mean_milli = 18'(mean);
			stats.max_diff   = max_acc;
			stats.pct_milli  = 17'(pct);
			stats.diff_sum   = sum_acc;
			stats.over_count = over_acc;
			sum_acc = '0;
			max_acc = '0;
			over_acc = '0;
		end
	endfunction

	function automatic pixel_t pix(input int r, g, b, sr, sg, sb);
		pixel_t p;
		p.ref_red   = 8'(r);
		p.ref_green = 8'(g);
		p.ref_blue  = 8'(b);
		p.scr_red   = 8'(sr);
		p.scr_green = 8'(sg);
		p.scr_blue  = 8'(sb);
		return p;
	endfunction

	function automatic step_t reg_step(input cfg_idx_t idx, input int value);
		step_t s;
		s.kind  = STEP_REG;
		s.idx   = idx;
		s.value = 13'(value);
		s.px    = '0;
		s.known = '0;
		return s;
	endfunction

	function automatic step_t pixel_step(input pixel_t px);
		step_t s;
		s.kind  = STEP_PIXEL;
		s.idx   = CFG_SCREEN_WIDTH;
		s.value = '0;
		s.px    = px;
		s.known = '0;
		return s;
	endfunction

	function automatic step_t known_step(input pixel_t px, input int mean, max_d, pct,
			sum, over);
		step_t s;
		s = pixel_step(px);
		s.kind             = STEP_PIXEL_KNOWN;
		s.known.mean_milli = 18'(mean);
		s.known.max_diff   = 8'(max_d);
		s.known.pct_milli  = 17'(pct);
		s.known.diff_sum   = 30'(sum);
		s.known.over_count = 21'(over);
		return s;
	endfunction

	function automatic geometry_t geom(input int sw, sh, ox, oy, rw, rh);
		geometry_t g;
		g.sw = 13'(sw);
		g.sh = 13'(sh);
		g.ox = 13'(ox);
		g.oy = 13'(oy);
		g.rw = 13'(rw);
		g.rh = 13'(rh);
		return g;
	endfunction

	function automatic logic [12:0] pick_span();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'($urandom);
			2: return 13'd4096;
			default: return 13'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [12:0] pick_ref();
		logic [10:0] v;
		case ($urandom_range(11))
			0: v = 11'd0;
			1: v = 11'($urandom);
			2: v = 11'($urandom_range(7, 20));
			default: v = 11'($urandom_range(1, 6));
		endcase
		return {2'($urandom), v};
	endfunction

	function automatic geometry_t random_geometry();
		geometry_t g;
		g.sw = pick_span();
		g.sh = pick_span();
		g.ox = 13'($urandom_range(16)) - 13'd4;
		g.oy = 13'($urandom_range(16)) - 13'd4;
		if ($urandom_range(9) == 0) g.ox = 13'($urandom);
		if ($urandom_range(9) == 0) g.oy = 13'($urandom);
		g.rw = pick_ref();
		g.rh = pick_ref();
		return g;
	endfunction

	function automatic void pick_pair(output logic [7:0] r, output logic [7:0] s);
		r = 8'($urandom);
		case ($urandom_range(9))
			0, 1, 2: s = 8'($urandom);
			3: s = r;
			default: s = r + 8'($urandom_range(40)) - 8'd20;
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		pick_pair(p.ref_red, p.scr_red);
		pick_pair(p.ref_green, p.scr_green);
		pick_pair(p.ref_blue, p.scr_blue);
		return p;
	endfunction

	function automatic logic [7:0] nudge(input logic [7:0] v, input logic [7:0] k);
		return (v < 8'd128) ? v + k : v - k;
	endfunction

	task automatic feed_pixel(input pixel_t px, input bit have_known, input result_t known);
		bit done;
		result_t stats;
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (full);
		tally_pixel(px, done, stats);
		if (have_known) stats_due.push_back(known);
		else if (done) stats_due.push_back(stats);
		sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [12:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SCREEN_WIDTH:  scr_w_reg = value;
			CFG_SCREEN_HEIGHT: scr_h_reg = value;
			CFG_OFFSET_X:      off_x_reg = value;
			CFG_OFFSET_Y:      off_y_reg = value;
			CFG_REF_WIDTH:     ref_w_reg = value[10:0];
			CFG_REF_HEIGHT:    ref_h_reg = value[10:0];
			default: ;
		endcase
	endtask

	// hold until every result is back, then let the back end go quiet
	task automatic settle();
		push <= 1'b0;
		while (stats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int idx, input geometry_t g, input int count, input bit tie);
		pixel_t px;
		settle();
		case (idx % 4)
			0: begin gap_pct = 0;  hold_pct = 0;  end
			1: begin gap_pct = 83; hold_pct = 0;  end
			2: begin gap_pct = 0;  hold_pct = 83; end
			default: begin gap_pct = 23; hold_pct = 23; end
		endcase
		write_reg(CFG_SCREEN_WIDTH, g.sw);
		write_reg(CFG_SCREEN_HEIGHT, g.sh);
		write_reg(CFG_OFFSET_X, g.ox);
		write_reg(CFG_OFFSET_Y, g.oy);
		write_reg(CFG_REF_WIDTH, g.rw);
		write_reg(CFG_REF_HEIGHT, g.rh);
		for (int i = 0; i < count; i++) begin
			px = random_pixel();
			if (tie) begin
				px.scr_red   = px.ref_red;
				px.scr_green = px.ref_green;
				px.scr_blue  = px.ref_blue;
				case (i)
					0: px.scr_red   = nudge(px.ref_red, 8'd17);
					1: px.scr_green = nudge(px.ref_green, 8'd16);
					2: px.scr_blue  = nudge(px.ref_blue, 8'd3);
					default: ;
				endcase
			end
			feed_pixel(px, 1'b0, '0);
		end
	endtask

	initial begin
		result_t want;
		wait (arst_n === 1'b1);
		forever begin
			pop <= ($urandom_range(99) >= hold_pct);
			@(posedge clk);
			if (pop && !empty) begin
				if (stats_due.size() == 0) begin
					$error("result popped with none outstanding: %p", result);
					faults++;
				end else begin
					want = stats_due.pop_front();
					if (result.mean_milli !== want.mean_milli) begin
						$error("mean_milli expected %0d got %0d", want.mean_milli,
							result.mean_milli);
						faults++;
					end
					if (result.max_diff !== want.max_diff) begin
						$error("max_diff expected %0d got %0d", want.max_diff, result.max_diff);
						faults++;
					end
					if (result.pct_milli !== want.pct_milli) begin
						$error("pct_milli expected %0d got %0d", want.pct_milli,
							result.pct_milli);
						faults++;
					end
					if (result.diff_sum !== want.diff_sum) begin
						$error("diff_sum expected %0d got %0d", want.diff_sum, result.diff_sum);
						faults++;
					end
					if (result.over_count !== want.over_count) begin
						$error("over_count expected %0d got %0d", want.over_count,
							result.over_count);
						faults++;
					end
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		opening.push_back(reg_step(CFG_REF_WIDTH, 1));
		opening.push_back(reg_step(CFG_REF_HEIGHT, 1));
		opening.push_back(known_step(pix(0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
		opening.push_back(known_step(pix(255, 255, 255, 0, 0, 0), 255000, 255, 100000, 765, 1));
		opening.push_back(known_step(pix(0, 0, 0, 255, 255, 255), 255000, 255, 100000, 765, 1));
		opening.push_back(known_step(pix(16, 0, 0, 0, 0, 0), 5333, 16, 0, 16, 0));
		opening.push_back(known_step(pix(0, 0, 0, 0, 0, 17), 5667, 17, 100000, 17, 1));
		opening.push_back(known_step(pix(200, 100, 50, 216, 84, 50), 10667, 16, 0, 32, 0));
		opening.push_back(reg_step(CFG_OFFSET_X, 639));
		opening.push_back(known_step(pix(7, 7, 7, 7, 7, 7), 0, 0, 0, 0, 0));
		opening.push_back(reg_step(CFG_OFFSET_X, 640));
		opening.push_back(known_step(pix(7, 7, 7, 7, 7, 7), 255000, 255, 100000, 765, 1));
		opening.push_back(reg_step(CFG_OFFSET_X, -1));
		opening.push_back(known_step(pix(1, 2, 3, 1, 2, 3), 255000, 255, 100000, 765, 1));
		opening.push_back(reg_step(CFG_OFFSET_X, 0));
		opening.push_back(reg_step(CFG_OFFSET_Y, 479));
		opening.push_back(known_step(pix(1, 2, 3, 1, 2, 3), 0, 0, 0, 0, 0));
		opening.push_back(reg_step(CFG_OFFSET_Y, 480));
		opening.push_back(known_step(pix(9, 9, 9, 9, 9, 9), 255000, 255, 100000, 765, 1));
		opening.push_back(reg_step(CFG_OFFSET_Y, -4096));
		opening.push_back(known_step(pix(9, 9, 9, 9, 9, 9), 255000, 255, 100000, 765, 1));
		opening.push_back(reg_step(CFG_OFFSET_Y, 0));
		opening.push_back(reg_step(CFG_OFFSET_X, 4095));
		opening.push_back(known_step(pix(9, 9, 9, 9, 9, 9), 255000, 255, 100000, 765, 1));
		opening.push_back(reg_step(CFG_OFFSET_X, 0));
		opening.push_back(reg_step(CFG_SCREEN_WIDTH, 0));
		opening.push_back(known_step(pix(9, 9, 9, 9, 9, 9), 255000, 255, 100000, 765, 1));
		opening.push_back(reg_step(CFG_SCREEN_WIDTH, 640));
		opening.push_back(reg_step(CFG_REF_WIDTH, 0));
		opening.push_back(reg_step(CFG_REF_HEIGHT, 0));
		opening.push_back(known_step(pix(10, 20, 30, 30, 20, 10), 13333, 20, 100000, 40, 1));
		opening.push_back(reg_step(CFG_REF_WIDTH, 2));
		opening.push_back(pixel_step(pix(255, 0, 128, 0, 255, 128)));
		opening.push_back(pixel_step(pix(40, 40, 40, 57, 23, 40)));
		opening.push_back(reg_step(CFG_REF_HEIGHT, 2));
		for (int i = 0; i < 4; i++) opening.push_back(pixel_step(random_pixel()));

		foreach (opening[i]) begin
			case (opening[i].kind)
				STEP_REG: begin
					settle();
					write_reg(opening[i].idx, opening[i].value);
				end
				STEP_PIXEL: feed_pixel(opening[i].px, 1'b0, '0);
				default: feed_pixel(opening[i].px, 1'b1, opening[i].known);
			endcase
		end

		// 8x8 image whose mean and percentage both land on a half
		run_phase(0, geom(640, 480, 0, 0, 8, 8), 64, 1'b1);
		// grow the sums on a large image, then shrink it so both results saturate
		run_phase(1, geom(0, 480, 0, 0, 4, 4), 8, 1'b0);
		run_phase(2, geom(0, 480, 0, 0, 1, 1), 1, 1'b0);
		run_phase(3, geom(640, 480, -2, 0, 3, 2047), 7, 1'b0);
		run_phase(4, geom(640, 480, -2, 0, 3, 2), 2, 1'b0);
		run_phase(5, geom(8191, 4100, 3500, 4095, 2047, 0), 1024, 1'b0);
		phase = 6;
		while (sent < RANDOM_ITEMS) begin
			run_phase(phase, random_geometry(), $urandom_range(1, 60), 1'b0);
			phase++;
		end

		settle();
		if (faults == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
